### rtl/spfs_pkg.sv
// ----------------------------------------------------------------------------
// spfs_pkg
// Shared types and constants for the smallest prime factor sieve core:
// request and response payloads, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package spfs_pkg;

    localparam int unsigned SPFS_TABLE_DEPTH = 65536;
    localparam logic [15:0] SPFS_LIMIT_RESET = 16'hFFFF;

    localparam logic OP_BUILD  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE     = 2'd1;
    localparam logic [1:0] STATUS_NOT_BUILT = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [15:0] query_value;
    } req_t;

    typedef struct packed {
        logic [15:0] factor;
        logic        is_prime;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_PRIME_RD,
        ST_PRIME_CHK,
        ST_MULT_RD,
        ST_MULT_CHK,
        ST_LOOK,
        ST_RESP
    } state_t;

endpackage

### rtl/smallest_prime_factor_sieve_core.sv
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve_core
// Builds a smallest-prime-factor table in on-chip memory and answers lookups.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_t  (opcode, query_value)
//   rsp      out        rsp_valid/rsp_stall  rsp_t  (factor, is_prime, status)
//   cfg      in         cfg_valid/cfg_ready  cfg_data (upper_limit)
//
// one item at a time; req_stall is high whenever the sequencer is not idle
// lookup: one registered table read, then ST_LOOK and ST_RESP to rsp_valid;
//   no ST_LOOK when the table is not built or the value is above the limit
// build: a fill pass over entries 0..L, then a table read and check per sieve
//   base and per multiple of each prime base from p*p, L the effective limit
// reset clears control, resets the limit; no clearing pass, table must be built
// a waiting response does not block the next request transfer
// ----------------------------------------------------------------------------
module smallest_prime_factor_sieve_core
    import spfs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = SPFS_TABLE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int unsigned AW    = $clog2(TABLE_DEPTH);
    localparam int unsigned TOP   = TABLE_DEPTH - 1;
    localparam logic [15:0] TOP16 = (TOP > 65535) ? 16'hFFFF : 16'(TOP);

    state_t      state_reg, state_next;
    logic [15:0] limit_reg;
    logic        ready_reg, ready_next;
    logic [8:0]  p_reg, p_next;
    logic [16:0] sq_reg, sq_next;
    logic [16:0] m_reg, m_next;
    logic [15:0] q_reg, q_next;
    rsp_t        res_reg, res_next;
    rsp_t        rsp_reg;
    logic        rsp_valid_reg;

    logic [15:0] eff_limit;
    logic [16:0] add_a, add_b, add_sum;
    logic [16:0] cmp_val;
    logic        in_limit;
    logic        req_xfer, cfg_xfer, rsp_load;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [15:0]   wr_data, rd_data;

    assign eff_limit = (limit_reg > TOP16) ? TOP16 : limit_reg;

    // shared adder and limit comparator
    assign add_sum  = add_a + add_b;
    assign in_limit = (cmp_val <= {1'b0, eff_limit});

    assign req_stall = (state_reg != ST_IDLE);
    // a limit write waits while a request is offered
    assign cfg_ready = (state_reg == ST_IDLE) && !req_valid;
    assign req_xfer  = req_valid && !req_stall;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign rsp_load  = (state_reg == ST_RESP) && (!rsp_valid_reg || !rsp_stall);

    spfs_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        p_next     = p_reg;
        sq_next    = sq_reg;
        m_next     = m_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        add_a      = m_reg;
        add_b      = 17'd1;
        cmp_val    = m_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(m_reg);
        wr_data    = m_reg[15:0];
        rd_en      = 1'b0;
        rd_addr    = AW'(m_reg);

        case (state_reg)
            ST_IDLE:
            begin
                cmp_val = {1'b0, req.query_value};
                if (req_xfer)
                begin
                    res_next = '{factor: 16'd0, is_prime: 1'b0, status: STATUS_OK};
                    q_next   = req.query_value;
                    if (req.opcode == OP_BUILD)
                    begin
                        m_next     = '0;
                        state_next = ST_FILL;
                    end
                    else if (!ready_reg)
                    begin
                        res_next.status = STATUS_NOT_BUILT;
                        state_next      = ST_RESP;
                    end
                    else if (!in_limit)
                    begin
                        res_next.status = STATUS_RANGE;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(req.query_value);
                        state_next = ST_LOOK;
                    end
                end
            end

            ST_FILL:
            begin
                // every entry starts as its own index
                if (in_limit)
                begin
                    wr_en  = 1'b1;
                    m_next = add_sum;
                end
                else
                begin
                    p_next     = 9'd2;
                    sq_next    = 17'd4;
                    state_next = ST_PRIME_RD;
                end
            end

            ST_PRIME_RD:
            begin
                cmp_val = sq_reg;
                if (in_limit)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(p_reg);
                    state_next = ST_PRIME_CHK;
                end
                else
                begin
                    ready_next = 1'b1;
                    state_next = ST_RESP;
                end
            end

            ST_PRIME_CHK:
            begin
                // (p+1)^2 = p^2 + 2p + 1
                add_a = sq_reg;
                add_b = {7'd0, p_reg, 1'b1};
                if (rd_data == {7'd0, p_reg})
                begin
                    m_next     = sq_reg;
                    state_next = ST_MULT_RD;
                end
                else
                begin
                    p_next     = p_reg + 9'd1;
                    sq_next    = add_sum;
                    state_next = ST_PRIME_RD;
                end
            end

            ST_MULT_RD:
            begin
                if (in_limit)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_MULT_CHK;
                end
                else
                begin
                    add_a      = sq_reg;
                    add_b      = {7'd0, p_reg, 1'b1};
                    p_next     = p_reg + 9'd1;
                    sq_next    = add_sum;
                    state_next = ST_PRIME_RD;
                end
            end

            ST_MULT_CHK:
            begin
                // only entries not yet claimed by a smaller prime
                add_b   = {8'd0, p_reg};
                wr_data = {7'd0, p_reg};
                wr_en   = (rd_data == m_reg[15:0]);
                m_next  = add_sum;
                state_next = ST_MULT_RD;
            end

            ST_LOOK:
            begin
                res_next.factor   = rd_data;
                res_next.is_prime = (q_reg >= 16'd2) && (rd_data == q_reg);
                state_next        = ST_RESP;
            end

            ST_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_xfer)
        begin
            ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b0;
            limit_reg     <= SPFS_LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            if (cfg_xfer)
            begin
                limit_reg <= cfg_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        sq_reg  <= sq_next;
        m_reg   <= m_next;
        q_reg   <= q_next;
        res_reg <= res_next;
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // table becomes ready only when the sieve runs out of bases
    a_ready_from_build: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_reg) |-> $past(state_reg) == ST_PRIME_RD)
        else $error("table ready set outside build completion");

    a_cfg_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_xfer |=> !ready_reg)
        else $error("limit write did not invalidate table");

    a_prime_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.is_prime) |-> (rsp.status == STATUS_OK && rsp.factor >= 16'd2))
        else $error("prime flag on non-ok response");

endmodule

### rtl/spfs_ram.sv
// ----------------------------------------------------------------------------
// spfs_ram
// Factor table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spfs_ram
    import spfs_pkg::*;
#(
    parameter int unsigned DEPTH = SPFS_TABLE_DEPTH,
    parameter int unsigned AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for smallest_prime_factor_sieve_core. Sends builds and
// lookups over a spread of limits, with random idling on both channels, and
// checks every response against a sieve kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
    import spfs_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1600000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned IDLE_PCT       = 32;
    localparam int unsigned FIRST_PRIME    = 2;
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS    = 120;
    localparam int unsigned RSP_HOLD_LEN   = 300;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    // bench copy of the table, the built flag and the limit register
    logic [15:0] spf_table [SPFS_TABLE_DEPTH];
    logic        table_built = 1'b0;
    logic [15:0] limit_reg   = SPFS_LIMIT_RESET;

    rsp_t        spf_rsp_q [$];
    rsp_t        spf_want;
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rsp_hold     = 0;
    bit          no_idle      = 1'b0;

    smallest_prime_factor_sieve_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int unsigned effective_limit();
        return (limit_reg > SPFS_TABLE_DEPTH - 1) ? SPFS_TABLE_DEPTH - 1 : limit_reg;
    endfunction

    function automatic void build_spf_table();
        int unsigned lim;
        int unsigned p;
        int unsigned m;
        lim = effective_limit();
        for (m = 0; m <= lim; m++)
            spf_table[m] = 16'(m);
        for (p = FIRST_PRIME; p * p <= lim; p++)
        begin
            if (spf_table[p] == p)
            begin
                for (m = p * p; m <= lim; m += p)
                begin
                    if (spf_table[m] == m)
                        spf_table[m] = 16'(p);
                end
            end
        end
        table_built = 1'b1;
    endfunction

    function automatic rsp_t predict_spf_rsp(input req_t item);
        rsp_t r;
        r = '0;
        r.status = STATUS_OK;
        if (item.opcode == OP_BUILD)
            build_spf_table();
        else if (!table_built)
            r.status = STATUS_NOT_BUILT;
        else if (item.query_value > effective_limit())
            r.status = STATUS_RANGE;
        else
        begin
            r.factor   = spf_table[item.query_value];
            r.is_prime = (item.query_value >= FIRST_PRIME) && (r.factor == item.query_value);
        end
        return r;
    endfunction

    // mostly in range, some just past the limit, some anywhere
    function automatic logic [15:0] pick_query();
        int unsigned lim;
        int unsigned q;
        lim = effective_limit();
        case ($urandom_range(9))
            7:       q = lim + $urandom_range(3);
            8, 9:    q = $urandom_range(16'hFFFF);
            default: q = $urandom_range(lim);
        endcase
        return (q > 16'hFFFF) ? 16'hFFFF : 16'(q);
    endfunction

    function automatic void note_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("%s", msg);
        fail_count++;
    endfunction

    // payload and valid change only while idle or right after a transfer
    task automatic send_req(input req_t item);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        spf_rsp_q = {spf_rsp_q, predict_spf_rsp(item)};
    endtask

    task automatic send_lookup(input logic [15:0] value);
        req_t item;
        item.opcode      = OP_LOOKUP;
        item.query_value = value;
        send_req(item);
    endtask

    task automatic send_build();
        req_t item;
        item.opcode      = OP_BUILD;
        item.query_value = 16'($urandom());
        send_req(item);
    endtask

    task automatic drain_rsp();
        req_valid <= 1'b0;
        while (spf_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // at least one request goes between two of these
    task automatic write_limit(input logic [15:0] value);
        drain_rsp();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        limit_reg   = value;
        table_built = 1'b0;
    endtask

    task automatic test_unbuilt_lookup();
        send_lookup(16'd0);
        send_lookup(16'hFFFF);
    endtask

    task automatic test_full_table();
        send_build();
        send_lookup(16'd0);
        send_lookup(16'd1);
        send_lookup(16'd2);
        send_lookup(16'd3);
        send_lookup(16'd63001);
        send_lookup(16'd65521);
        send_lookup(16'd65534);
        send_lookup(16'hFFFF);
        send_lookup(16'h5555);
        send_lookup(16'hAAAA);
    endtask

    task automatic test_same_limit_write();
        write_limit(SPFS_LIMIT_RESET);
        send_lookup(16'd7);
    endtask

    task automatic test_tiny_limits();
        write_limit(16'd0);
        // not built wins over the range check
        send_lookup(16'hFFFF);
        send_build();
        send_lookup(16'd0);
        send_lookup(16'd1);
        write_limit(16'd1);
        send_build();
        send_lookup(16'd1);
        send_lookup(16'd2);
        write_limit(16'd4);
        send_build();
        send_lookup(16'd4);
        send_lookup(16'd3);
        send_lookup(16'd5);
    endtask

    task automatic test_random_limits();
        int unsigned phase;
        int unsigned lim;
        int unsigned k;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                lim = $urandom_range(15);
            else if (phase == 1)
                lim = $urandom_range(4095, 2048);
            else
                lim = $urandom_range(1500, 2);
            write_limit(16'(lim));
            repeat ($urandom_range(3))
                send_lookup(pick_query());
            send_build();
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(99) < 2)
                    send_build();
                else
                    send_lookup(pick_query());
            end
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (100)
            send_lookup(pick_query());
        no_idle = 1'b0;
    endtask

    task automatic test_rsp_backpressure();
        rsp_hold = RSP_HOLD_LEN;
        repeat (20)
            send_lookup(pick_query());
        drain_rsp();
        repeat (20)
            send_lookup(pick_query());
    endtask

    always @(posedge clk)
    begin
        if (rsp_hold != 0)
        begin
            rsp_stall <= 1'b1;
            rsp_hold = rsp_hold - 1;
        end
        else
            rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            if (spf_rsp_q.size() == 0)
                note_failure($sformatf("%0t unexpected response factor=%0d is_prime=%0d status=%0d",
                    $time, rsp.factor, rsp.is_prime, rsp.status));
            else
            begin
                spf_want = spf_rsp_q.pop_front();
                if (rsp.factor !== spf_want.factor || rsp.is_prime !== spf_want.is_prime ||
                    rsp.status !== spf_want.status)
                    note_failure($sformatf(
                        "%0t mismatch factor %0d/%0d is_prime %0d/%0d status %0d/%0d (exp/act)",
                        $time, spf_want.factor, rsp.factor, spf_want.is_prime, rsp.is_prime,
                        spf_want.status, rsp.status));
            end
        end
    end

    // a full-size build runs long without any transfer
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL smallest_prime_factor_sieve_core");
            $finish;
        end
    end

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        test_unbuilt_lookup();
        test_full_table();
        test_same_limit_write();
        test_tiny_limits();
        test_random_limits();
        test_back_to_back();
        test_rsp_backpressure();
        drain_rsp();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("PASS smallest_prime_factor_sieve_core");
        else
            $display("FAIL smallest_prime_factor_sieve_core");
        $finish;
    end

endmodule
